// File: design/lsp_pkg.sv
`default_nettype none
package lsp_pkg;

  // Operation codes carried by in_func
  typedef enum logic [2:0] {
    FUNC_PUSH   = 3'd0,
    FUNC_POP    = 3'd1,
    FUNC_PEEK   = 3'd2,
    FUNC_TOP    = 3'd3,
    FUNC_BOTTOM = 3'd4
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_BADPOS    = 2'd3
  } status_t;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned POS_W   = 5;
  localparam int unsigned FILL_W  = 5;
  localparam int unsigned STAT_W  = 2;

  // Shift control broadcast to every cell
  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctrl_t;

endpackage
`default_nettype wire

// File: design/lifo_stack_with_peek.sv
// LIFO stack of signed 32-bit words, DEPTH entries, built as a row of cells
// with the top word always in the first cell.
// Input channel: in_valid/in_stall carry in_func, in_push_value and
// in_peek_position. Output channel: out_valid/out_stall carry out_read_data,
// out_status, out_fill_count, out_is_empty and out_is_full; every request
// gives exactly one result word.
// The result is registered and appears in the cycle after the request is taken.
// Throughput: one request per cycle while in_stall is low; push and pop shift the
// whole row at once, and peek or bottom reads pick one cell through a select bus.
// When the receiver stalls, the pending result holds in the output register
// and in_stall rises until it is taken, so no result is lost.
// Reset (rst_n low, synchronous) empties the stack and drops any pending
// result; the stored words are not cleared and are never read before written.
// Codes in in_func above 4 are ignored and return status ok with zero data.
`default_nettype none
module lifo_stack_with_peek #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [lsp_pkg::FUNC_W-1:0]         in_func,
  input  wire logic signed [lsp_pkg::WORD_W-1:0]  in_push_value,
  input  wire logic [lsp_pkg::POS_W-1:0]          in_peek_position,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic signed [lsp_pkg::WORD_W-1:0]       out_read_data,
  output logic [lsp_pkg::STAT_W-1:0]              out_status,
  output logic [lsp_pkg::FILL_W-1:0]              out_fill_count,
  output logic                                    out_is_empty,
  output logic                                    out_is_full
);
  import lsp_pkg::*;

  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned PW = (CW > POS_W) ? CW : POS_W;

  logic                 accept;
  logic [CW-1:0]        count_r;
  logic [CW-1:0]        count_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic [WORD_W-1:0]    read_data_r;
  logic [WORD_W-1:0]    read_data_nxt;
  status_t              status_r;
  status_t              status_nxt;
  logic [FILL_W-1:0]    fill_r;
  logic                 empty_r;
  logic                 full_r;
  logic                 is_empty;
  logic                 is_full;
  logic [PW-1:0]        pos_ext;
  logic [PW-1:0]        cnt_ext;
  logic [PW-1:0]        sel_idx;
  logic [WORD_W-1:0]    sel_word;
  func_t                func;
  shift_ctrl_t          ctrl;

  logic [WORD_W-1:0]    cell_q   [DEPTH];
  logic [WORD_W-1:0]    cell_sel [DEPTH];

  assign accept   = in_valid && !in_stall;
  assign in_stall = out_valid_r && out_stall;
  assign func     = func_t'(in_func);
  assign is_empty = (count_r == '0);
  assign is_full  = (count_r == CW'(DEPTH));
  assign pos_ext  = PW'(in_peek_position);
  assign cnt_ext  = PW'(count_r);

  // Row of cells; cell 0 holds the top word
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WORD_W-1:0] above;
    logic [WORD_W-1:0] below;
    if (i == 0) begin : g_first
      assign above = in_push_value;
    end else begin : g_mid
      assign above = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign below = '0;
    end else begin : g_inner
      assign below = cell_q[i+1];
    end
    lsp_cell #(
      .IDX (i),
      .SW  (PW)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .from_above (above),
      .from_below (below),
      .sel_idx    (sel_idx),
      .data_q     (cell_q[i]),
      .sel_data   (cell_sel[i])
    );
  end

  // Merge the select bus
  always_comb begin
    sel_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_word = sel_word | cell_sel[i];
    end
  end

  // Decode the request
  always_comb begin
    ctrl          = '0;
    count_nxt     = count_r;
    read_data_nxt = '0;
    status_nxt    = ST_OK;
    sel_idx       = cnt_ext - PW'(1);
    unique case (func)
      FUNC_PUSH: begin
        if (is_full) begin
          status_nxt = ST_OVERFLOW;
        end else begin
          ctrl.push = accept;
          count_nxt = CW'(count_r + 1'b1);
        end
      end
      FUNC_POP: begin
        if (is_empty) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          ctrl.pop      = accept;
          count_nxt     = CW'(count_r - 1'b1);
          read_data_nxt = cell_q[0];
        end
      end
      FUNC_PEEK: begin
        sel_idx = pos_ext - PW'(1);
        if (pos_ext == '0 || pos_ext > cnt_ext) begin
          status_nxt = ST_BADPOS;
        end else begin
          read_data_nxt = sel_word;
        end
      end
      FUNC_TOP: begin
        if (is_empty) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          read_data_nxt = cell_q[0];
        end
      end
      FUNC_BOTTOM: begin
        if (is_empty) begin
          status_nxt = ST_UNDERFLOW;
        end else begin
          read_data_nxt = sel_word;
        end
      end
      default: begin
      end
    endcase
  end

  // Hold the result until it is taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Advance count and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  // Load the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      read_data_r <= read_data_nxt;
      status_r    <= status_nxt;
      fill_r      <= FILL_W'(count_nxt);
      empty_r     <= (count_nxt == '0);
      full_r      <= (count_nxt == CW'(DEPTH));
    end
  end

  assign out_valid      = out_valid_r;
  assign out_read_data  = read_data_r;
  assign out_status     = status_r;
  assign out_fill_count = fill_r;
  assign out_is_empty   = empty_r;
  assign out_is_full    = full_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("element count above depth");

  a_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    accept && func == FUNC_PUSH && is_full |=> status_r == ST_OVERFLOW && full_r)
    else $error("push to full stack not reported as overflow");

  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    accept && func == FUNC_PUSH && !is_full |=> count_r == CW'($past(count_r) + 1'b1))
    else $error("push did not advance count");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && status_r != ST_OK |-> read_data_r == '0)
    else $error("nonzero data with error status");

endmodule
`default_nettype wire

// File: design/lsp_cell.sv
`default_nettype none
module lsp_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned SW  = 5
) (
  input  wire logic                        clk,
  input  wire lsp_pkg::shift_ctrl_t        ctrl,
  input  wire logic [lsp_pkg::WORD_W-1:0]  from_above,
  input  wire logic [lsp_pkg::WORD_W-1:0]  from_below,
  input  wire logic [SW-1:0]               sel_idx,
  output logic      [lsp_pkg::WORD_W-1:0]  data_q,
  output logic      [lsp_pkg::WORD_W-1:0]  sel_data
);
  import lsp_pkg::*;

  logic [WORD_W-1:0] data_r;
  logic [WORD_W-1:0] data_nxt;
  logic              hit;

  // Take the word from above on push, from below on pop, else hold
  always_comb begin
    data_nxt = data_r;
    if (ctrl.push) begin
      data_nxt = from_above;
    end else if (ctrl.pop) begin
      data_nxt = from_below;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // Drive the shared read bus only when this cell is selected
  assign hit      = (sel_idx == SW'(IDX));
  assign sel_data = data_r & {WORD_W{hit}};
  assign data_q   = data_r;

endmodule
`default_nettype wire
